/* src/pst_pkg.sv */
// Package with shared types and constants of the probe station table.
package pst_pkg;
  localparam int TABLE_ENTRIES = 24;
  localparam int SSID_MAX = 32;
  localparam int HEADER_BYTES = 24;
  localparam int SLOT_W = 5;
  localparam int SSID_W = 5;
  localparam int SSID_AW = 10;
  localparam int SCAN_W = 5;
  localparam logic [3:0] PROBE_REQ_SUBTYPE = 4'h4;
  localparam logic [15:0] HITS_MAX = 16'hFFFF;
  localparam logic [5:0] POS_SAT = 6'd63;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COPY,
    ST_READ,
    ST_DONE
  } state_t;

  // Search word handed from cell to cell.
  typedef struct packed {
    logic        found;
    logic        have_free;
    logic [SLOT_W-1:0] free_slot;
    logic        have_weak;
    logic [SLOT_W-1:0] weak_slot;
    logic [15:0] weak_hits;
    logic [SLOT_W-1:0] match_slot;
  } scan_t;

  typedef struct packed {
    logic        valid;
    logic [47:0] mac;
    logic [7:0]  signal;
    logic [15:0] hits;
    logic [5:0]  ssid_len;
  } entry_t;
endpackage

/* src/probe_station_table_unit.sv */
// Top level of the probe station table.
// Requests enter on start while busy is low; operation selects frame byte,
// read, clear or none. Frame bytes that are not the frame end give no
// result. At the end of a probe request the cells are walked one per cycle
// by a search word registered between them, then the SSID is copied into
// SSID storage one byte per cycle, and the report shows on out_valid for
// one cycle. Other frame ends go straight to the report, with frame_taken
// low. A read passes through a read state because the SSID storage has a
// registered read port. A clear gives no result. The receiver cannot
// stall: each result is on the ports for exactly one cycle. Reset empties
// the table and the frame parser; SSID storage is left as is and only read
// below the stored length.
module probe_station_table_unit
  import pst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  input  logic [3:0]  frame_subtype,
  input  logic [47:0] source_mac,
  input  logic signed [7:0] signal_strength,
  input  logic [4:0]  read_slot,
  input  logic [4:0]  read_ssid_pos,
  output logic        out_valid,
  output logic        result_kind,
  output logic        frame_taken,
  output logic [4:0]  slot,
  output logic        new_entry,
  output logic        entry_used,
  output logic [47:0] entry_mac,
  output logic signed [7:0] entry_signal,
  output logic [15:0] hit_count,
  output logic [5:0]  ssid_length,
  output logic [7:0]  ssid_char
);
  state_t state, state_next;
  logic accept;
  assign accept = start && !busy;

  // Parser state.
  logic [5:0] byte_position;
  logic       element_tag_ok;
  logic [7:0] declared_ssid_len;
  logic [5:0] ssid_zero_cut;
  logic [7:0] ssid_scratch [SSID_MAX];

  // Request hold.
  logic [47:0] req_mac;
  logic [7:0]  req_signal;
  logic [5:0]  req_eff;
  logic [SLOT_W-1:0] rd_slot;
  logic [SSID_W-1:0] rd_pos;

  // Cell chain.
  scan_t  scan_in  [TABLE_ENTRIES];
  scan_t  scan_out [TABLE_ENTRIES];
  entry_t entries  [TABLE_ENTRIES];
  logic   cell_wr  [TABLE_ENTRIES];
  scan_t  scan;
  logic [SCAN_W-1:0] scan_idx;
  entry_t wdata;
  logic clear_tbl;
  logic [SLOT_W-1:0] sel;
  logic fresh;
  logic [5:0] copy_idx;

  assign clear_tbl = accept && op_t'(operation) == OP_CLEAR;

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      assign scan_in[g] = scan;
      assign cell_wr[g] = (state == ST_COPY) && copy_idx == 6'd0 &&
                          sel == SLOT_W'(g);
      pst_cell u_cell (
        .clk(clk), .rst(rst), .index(SLOT_W'(g)), .clear(clear_tbl),
        .write(cell_wr[g]), .wdata(wdata), .key(req_mac),
        .scan_in(scan_in[g]), .scan_out(scan_out[g]), .entry(entries[g])
      );
    end
  endgenerate

  // SSID storage.
  logic [7:0] ssid_mem [TABLE_ENTRIES*SSID_MAX];
  logic [7:0] mem_q;
  logic [SSID_AW-1:0] wr_addr, rd_addr;
  assign wr_addr = SSID_AW'(sel) * SSID_AW'(SSID_MAX) + SSID_AW'(copy_idx[4:0]);
  assign rd_addr = SSID_AW'(read_slot) * SSID_AW'(SSID_MAX) + SSID_AW'(read_ssid_pos);

  always_ff @(posedge clk) begin
    if (state == ST_COPY && copy_idx < req_eff) begin
      ssid_mem[wr_addr] <= ssid_scratch[copy_idx[4:0]];
    end
    mem_q <= ssid_mem[rd_addr];
  end

  // Frame length including the current byte.
  logic [6:0] flen;
  assign flen = 7'(byte_position) + 7'd1;

  // Position of the current byte within the SSID, counted from the first SSID byte.
  logic [5:0] sidx;
  assign sidx = byte_position - 6'(HEADER_BYTES + 2);

  always_ff @(posedge clk) begin
    if (accept && op_t'(operation) == OP_BYTE && byte_position >= 6'(HEADER_BYTES + 2)
        && sidx < 6'(SSID_MAX)) begin
      ssid_scratch[sidx[4:0]] <= frame_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      element_tag_ok <= 1'b0;
      declared_ssid_len <= '0;
      ssid_zero_cut <= '0;
    end else if (accept && op_t'(operation) == OP_BYTE) begin
      if (frame_end) begin
        byte_position <= '0;
        element_tag_ok <= 1'b0;
        declared_ssid_len <= '0;
        ssid_zero_cut <= '0;
      end else begin
        if (byte_position < POS_SAT) byte_position <= byte_position + 6'd1;
        if (byte_position == 6'(HEADER_BYTES)) element_tag_ok <= (frame_byte == 8'd0);
        if (byte_position == 6'(HEADER_BYTES + 1)) declared_ssid_len <= frame_byte;
        if (byte_position >= 6'(HEADER_BYTES + 2) && sidx < 6'(SSID_MAX) &&
            sidx == ssid_zero_cut && frame_byte != 8'd0) begin
          ssid_zero_cut <= sidx + 6'd1;
        end
      end
    end
  end

  // The final byte itself may complete the SSID; fold it in combinationally.
  logic [5:0] zc_final;
  logic [5:0] eff_final;
  logic [7:0] dlen_final;
  logic       tag_final;
  logic [5:0] slen_f;
  always_comb begin
    zc_final = ssid_zero_cut;
    if (byte_position >= 6'(HEADER_BYTES + 2) && sidx < 6'(SSID_MAX) &&
        sidx == ssid_zero_cut && frame_byte != 8'd0) zc_final = sidx + 6'd1;
    dlen_final = (byte_position == 6'(HEADER_BYTES + 1)) ? frame_byte : declared_ssid_len;
    tag_final = (byte_position == 6'(HEADER_BYTES)) ? (frame_byte == 8'd0) : element_tag_ok;
    slen_f = (dlen_final > 8'(SSID_MAX)) ? 6'(SSID_MAX) : dlen_final[5:0];
    eff_final = '0;
    if (flen >= 7'(HEADER_BYTES + 2) && tag_final && slen_f != 0 &&
        7'(HEADER_BYTES + 2) + 7'(slen_f) <= flen) begin
      eff_final = (slen_f < zc_final) ? slen_f : zc_final;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mac <= source_mac;
      req_signal <= signal_strength;
      req_eff <= eff_final;
      rd_slot <= read_slot;
      rd_pos <= read_ssid_pos;
    end
  end

  // Scan register steps through the chain one cell per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      copy_idx <= '0;
      scan <= '0;
    end else begin
      if (state == ST_IDLE) begin
        scan <= '0;
        scan_idx <= '0;
        copy_idx <= '0;
      end else if (state == ST_SCAN) begin
        scan <= scan_out[scan_idx];
        scan_idx <= scan_idx + SCAN_W'(1);
      end else if (state == ST_COPY) begin
        copy_idx <= copy_idx + 6'd1;
      end
    end
  end

  // Cells are read one at a time: each cell sees the same word but only the
  // current index is taken, so the scan is serial.
  always_comb begin
    if (scan.found) sel = scan.match_slot;
    else if (scan.have_free) sel = scan.free_slot;
    else sel = scan.weak_slot;
    fresh = !scan.found;
    wdata = entries[sel];
    if (fresh) begin
      wdata.valid = 1'b1;
      wdata.mac = req_mac;
      wdata.hits = '0;
      wdata.ssid_len = '0;
    end
    wdata.signal = req_signal;
    if (wdata.hits != HITS_MAX) wdata.hits = wdata.hits + 16'd1;
    if (req_eff != 0) wdata.ssid_len = req_eff;
  end

  logic is_probe;
  always_ff @(posedge clk) begin
    if (accept) is_probe <= (frame_subtype == PROBE_REQ_SUBTYPE);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(operation))
            OP_READ: state_next = ST_READ;
            OP_BYTE: if (frame_end) state_next =
                       (frame_subtype == PROBE_REQ_SUBTYPE) ? ST_SCAN : ST_DONE;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: if (scan_idx == SCAN_W'(TABLE_ENTRIES - 1)) state_next = ST_COPY;
      ST_COPY: if (copy_idx + 6'd1 >= req_eff && copy_idx != 6'd0 || req_eff <= 6'd1)
                 state_next = ST_DONE;
      ST_READ: state_next = ST_IDLE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  logic [SLOT_W-1:0] done_slot;
  logic done_fresh;
  always_ff @(posedge clk) begin
    if (state == ST_COPY && copy_idx == 6'd0) begin
      done_slot <= sel;
      done_fresh <= fresh;
    end
  end

  entry_t rd_e;
  logic rd_ok;
  always_comb begin
    busy = (state != ST_IDLE);
    rd_ok = rd_slot < SLOT_W'(TABLE_ENTRIES);
    rd_e = rd_ok ? entries[rd_slot] : '0;
    out_valid = 1'b0;
    result_kind = 1'b0;
    frame_taken = 1'b0;
    slot = '0;
    new_entry = 1'b0;
    entry_used = 1'b0;
    entry_mac = '0;
    entry_signal = '0;
    hit_count = '0;
    ssid_length = '0;
    ssid_char = '0;
    case (state)
      ST_READ: begin
        out_valid = 1'b1;
        result_kind = 1'b1;
        slot = rd_slot;
        entry_used = rd_e.valid;
        entry_mac = rd_e.mac;
        entry_signal = rd_e.signal;
        hit_count = rd_e.hits;
        ssid_length = rd_e.ssid_len;
        ssid_char = (6'(rd_pos) < rd_e.ssid_len) ? mem_q : 8'd0;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (is_probe) begin
          frame_taken = 1'b1;
          slot = done_slot;
          new_entry = done_fresh;
          entry_used = entries[done_slot].valid;
          entry_mac = entries[done_slot].mac;
          entry_signal = entries[done_slot].signal;
          hit_count = entries[done_slot].hits;
          ssid_length = entries[done_slot].ssid_len;
        end
      end
      default: out_valid = 1'b0;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy) else $error("result outside a busy period");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |=> !out_valid) else $error("result held two cycles");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_idx < SCAN_W'(TABLE_ENTRIES)) else $error("scan overrun");
`endif
endmodule

/* src/pst_cell.sv */
// One table cell: holds a station entry and folds it into the search word.
module pst_cell
  import pst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] index,
  input  logic              clear,
  input  logic              write,
  input  entry_t            wdata,
  input  logic [47:0]       key,
  input  scan_t             scan_in,
  output scan_t             scan_out,
  output entry_t            entry
);
  entry_t e;
  assign entry = e;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      e <= '0;
    end else if (write) begin
      e <= wdata;
    end
  end

  always_comb begin
    scan_out = scan_in;
    if (!scan_in.found) begin
      if (e.valid && e.mac == key) begin
        scan_out.found = 1'b1;
        scan_out.match_slot = index;
      end else if (!e.valid) begin
        if (!scan_in.have_free) begin
          scan_out.have_free = 1'b1;
          scan_out.free_slot = index;
        end
      end else if (!scan_in.have_weak || e.hits < scan_in.weak_hits) begin
        scan_out.have_weak = 1'b1;
        scan_out.weak_slot = index;
        scan_out.weak_hits = e.hits;
      end
    end
  end
endmodule

/* tb/pst_checker.sv */
// Checker that predicts the probe station table and compares its results.
`timescale 1ns / 100ps
module pst_checker
  import pst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  input  logic [3:0]  frame_subtype,
  input  logic [47:0] source_mac,
  input  logic [7:0]  signal_strength,
  input  logic [4:0]  read_slot,
  input  logic [4:0]  read_ssid_pos,
  input  logic        out_valid,
  input  logic        result_kind,
  input  logic        frame_taken,
  input  logic [4:0]  slot,
  input  logic        new_entry,
  input  logic        entry_used,
  input  logic [47:0] entry_mac,
  input  logic [7:0]  entry_signal,
  input  logic [15:0] hit_count,
  input  logic [5:0]  ssid_length,
  input  logic [7:0]  ssid_char,
  output int          fail_count,
  output int          pending_count,
  output int          report_count,
  output int          taken_count,
  output int          read_count
);
  typedef struct packed {
    logic        kind;
    logic        taken;
    logic [4:0]  slot;
    logic        fresh;
    logic        used;
    logic [47:0] mac;
    logic [7:0]  sig;
    logic [15:0] hits;
    logic [5:0]  len;
    logic [7:0]  chr;
  } station_reply_t;

  logic        st_valid [TABLE_ENTRIES];
  logic [47:0] st_mac   [TABLE_ENTRIES];
  logic [7:0]  st_sig   [TABLE_ENTRIES];
  logic [15:0] st_hits  [TABLE_ENTRIES];
  logic [5:0]  st_len   [TABLE_ENTRIES];
  logic [7:0]  st_ssid  [TABLE_ENTRIES][SSID_MAX];
  int          pos, tag_ok, decl_len, zero_cut;
  logic [7:0]  scratch  [SSID_MAX];
  station_reply_t expected_replies[$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic wipe_table();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      st_valid[i] = 1'b0; st_mac[i] = '0; st_sig[i] = '0; st_hits[i] = '0; st_len[i] = '0;
    end
  endtask

  function automatic station_reply_t entry_view(int s, int p);
    station_reply_t r;
    r = '0;
    r.used = st_valid[s];
    r.mac = st_mac[s];
    r.sig = st_sig[s];
    r.hits = st_hits[s];
    r.len = st_len[s];
    r.chr = (p < st_len[s]) ? st_ssid[s][p] : 8'd0;
    return r;
  endfunction

  task automatic predict_request();
    station_reply_t r;
    int s, free_s, weak_s, eff, slen, flen, cur;
    logic fresh;
    r = '0;
    case (op_t'(operation))
      OP_READ: begin
        if (read_slot < TABLE_ENTRIES) r = entry_view(read_slot, read_ssid_pos);
        r.kind = 1'b1;
        r.slot = read_slot;
        expected_replies.push_back(r);
        read_count++;
      end
      OP_CLEAR: wipe_table();
      OP_BYTE: begin
        cur = pos;
        if (cur == HEADER_BYTES) tag_ok = (frame_byte == 0);
        else if (cur == HEADER_BYTES + 1) decl_len = frame_byte;
        else if (cur >= HEADER_BYTES + 2 && cur - HEADER_BYTES - 2 < SSID_MAX) begin
          scratch[cur - HEADER_BYTES - 2] = frame_byte;
          if (cur - HEADER_BYTES - 2 == zero_cut && frame_byte != 0) zero_cut++;
        end
        if (pos < 63) pos++;
        if (frame_end) begin
          report_count++;
          if (frame_subtype == PROBE_REQ_SUBTYPE) begin
            flen = cur + 1;
            slen = decl_len > SSID_MAX ? SSID_MAX : decl_len;
            eff = 0;
            if (flen >= HEADER_BYTES + 2 && tag_ok != 0 && slen > 0 &&
                HEADER_BYTES + 2 + slen <= flen)
              eff = slen < zero_cut ? slen : zero_cut;
            s = -1; free_s = -1; weak_s = 0;
            for (int i = 0; i < TABLE_ENTRIES && s < 0; i++) begin
              if (st_valid[i] && st_mac[i] == source_mac) s = i;
              if (!st_valid[i] && free_s < 0) free_s = i;
              if (st_valid[i] && st_hits[i] < st_hits[weak_s]) weak_s = i;
            end
            if (s < 0) s = free_s >= 0 ? free_s : weak_s;
            fresh = !st_valid[s] || st_mac[s] != source_mac;
            if (fresh) begin
              st_valid[s] = 1'b1; st_mac[s] = source_mac; st_hits[s] = '0; st_len[s] = '0;
            end
            st_sig[s] = signal_strength;
            if (st_hits[s] != HITS_MAX) st_hits[s]++;
            if (eff > 0) begin
              for (int k = 0; k < eff; k++) st_ssid[s][k] = scratch[k];
              st_len[s] = 6'(eff);
            end
            r = entry_view(s, 0);
            r.chr = 8'd0;
            r.taken = 1'b1;
            r.slot = 5'(s);
            r.fresh = fresh;
            taken_count++;
          end
          expected_replies.push_back(r);
          pos = 0; tag_ok = 0; decl_len = 0; zero_cut = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_reply();
    station_reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch("unexpected result", 64'd1, 64'd0);
      return;
    end
    want = expected_replies.pop_front();
    if (result_kind != want.kind) report_mismatch("result_kind", result_kind, want.kind);
    if (frame_taken != want.taken) report_mismatch("frame_taken", frame_taken, want.taken);
    if (slot != want.slot) report_mismatch("slot", slot, want.slot);
    if (new_entry != want.fresh) report_mismatch("new_entry", new_entry, want.fresh);
    if (entry_used != want.used) report_mismatch("entry_used", entry_used, want.used);
    if (entry_mac != want.mac) report_mismatch("entry_mac", entry_mac, want.mac);
    if (entry_signal != want.sig) report_mismatch("entry_signal", entry_signal, want.sig);
    if (hit_count != want.hits) report_mismatch("hit_count", hit_count, want.hits);
    if (ssid_length != want.len) report_mismatch("ssid_length", ssid_length, want.len);
    if (ssid_char != want.chr) report_mismatch("ssid_char", ssid_char, want.chr);
  endtask

  initial begin
    fail_count = 0; report_count = 0; taken_count = 0; read_count = 0;
    pending_count = 0;
    pos = 0; tag_ok = 0; decl_len = 0; zero_cut = 0;
    wipe_table();
  end

  // A result is compared before a request is predicted, since the result was
  // produced by earlier requests.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid) compare_reply();
      if (start && !busy) predict_request();
    end
    pending_count = expected_replies.size();
  end
endmodule

/* tb/tb_probe_station_table_unit.sv */
// Testbench top: drives requests into the probe station table and gives the verdict.
`timescale 1ns / 100ps
module tb_probe_station_table_unit;
  import pst_pkg::*;

  logic        clk, rst, start, busy;
  logic [1:0]  operation;
  logic [7:0]  frame_byte;
  logic        frame_end;
  logic [3:0]  frame_subtype;
  logic [47:0] source_mac;
  logic signed [7:0] signal_strength;
  logic [4:0]  read_slot, read_ssid_pos;
  logic        out_valid, result_kind, frame_taken, new_entry, entry_used;
  logic [4:0]  slot;
  logic [47:0] entry_mac;
  logic signed [7:0] entry_signal;
  logic [15:0] hit_count;
  logic [5:0]  ssid_length;
  logic [7:0]  ssid_char;
  int          fail_count, pending_count, report_count, taken_count, read_count;
  int          cycle_count;
  int          frames_sent;
  logic [47:0] mac_pool[8];
  logic [7:0]  frame_buf[$];

  probe_station_table_unit i_dut (.*);

  pst_checker i_checker (.*);

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_probe_station_table_unit failed");
      $finish;
    end
  end

  // Drops start and scrambles operation and frame_byte while nothing is offered.
  task automatic release_bus();
    start <= 0;
    operation <= 2'($urandom_range(0, 3));
    frame_byte <= 8'($urandom);
  endtask

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) release_bus();
    repeat (n) @(posedge clk);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain();
    release_bus();
    @(posedge clk);
    wait (pending_count == 0);
  endtask

  // Holds one request until the block takes it.
  task automatic send_request(input op_t op, input logic [7:0] b, input logic fe,
                              input logic [3:0] sub, input logic [47:0] mac,
                              input logic [7:0] sig, input logic [4:0] rs,
                              input logic [4:0] rp);
    start <= 1;
    operation <= op; frame_byte <= b; frame_end <= fe; frame_subtype <= sub;
    source_mac <= mac; signal_strength <= sig; read_slot <= rs; read_ssid_pos <= rp;
    do @(posedge clk); while (busy);
  endtask

  // Builds a frame with a 24-byte header and an SSID element shaped by the arguments.
  task automatic build_frame(input int tag, input int decl, input int body,
                             input int zero_at);
    frame_buf.delete();
    for (int i = 0; i < HEADER_BYTES; i++) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(8'(tag));
    frame_buf.push_back(8'(decl));
    for (int i = 0; i < body; i++)
      frame_buf.push_back(i == zero_at ? 8'd0 : 8'($urandom_range(1, 255)));
  endtask

  task automatic send_frame(input logic [3:0] sub, input logic [47:0] mac,
                            input logic [7:0] sig, input bit gaps);
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_request(OP_BYTE, frame_buf[i], i == frame_buf.size() - 1, sub, mac, sig,
                   5'($urandom), 5'($urandom));
      if (gaps) random_gap();
    end
    frames_sent++;
  endtask

  task automatic send_read(input logic [4:0] rs, input logic [4:0] rp);
    send_request(OP_READ, 8'($urandom), 1'($urandom), 4'($urandom),
                 48'({$urandom, $urandom}), 8'($urandom), rs, rp);
  endtask

  initial begin
    int len, decl, kind, sub;
    rst = 1; start = 0; operation = OP_BYTE; frame_byte = 0; frame_end = 0;
    frame_subtype = 0; source_mac = 0; signal_strength = 0; read_slot = 0;
    read_ssid_pos = 0; cycle_count = 0; frames_sent = 0;
    for (int i = 0; i < 8; i++) mac_pool[i] = 48'({$urandom, $urandom});
    mac_pool[0] = '1;
    mac_pool[1] = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: read of an empty table, out-of-range slot, extreme fields.
    send_read(5'd0, 5'd0);
    send_read(5'd31, 5'd31);
    build_frame(0, 32, 32, -1);
    send_frame(PROBE_REQ_SUBTYPE, mac_pool[0], 8'h7F, 1'b0);
    send_read(5'd0, 5'd31);
    build_frame(0, 200, 40, 5);  // length above the cap, cut at a zero byte
    send_frame(PROBE_REQ_SUBTYPE, mac_pool[1], 8'h80, 1'b0);
    send_read(5'd1, 5'd4);
    build_frame(0, 10, 5, -1);   // element runs past the frame end
    send_frame(PROBE_REQ_SUBTYPE, mac_pool[0], 8'h00, 1'b0);
    build_frame(1, 4, 4, -1);    // wrong tag
    send_frame(PROBE_REQ_SUBTYPE, mac_pool[2], 8'h11, 1'b0);
    build_frame(0, 3, 3, 0);     // SSID opens with a zero byte
    send_frame(PROBE_REQ_SUBTYPE, mac_pool[2], 8'h22, 1'b0);
    build_frame(0, 0, 0, -1);
    send_frame(4'hF, mac_pool[3], 8'h33, 1'b0);  // not a probe request
    frame_buf.delete();
    frame_buf.push_back(8'hAA);  // single-byte frame
    send_frame(PROBE_REQ_SUBTYPE, mac_pool[3], 8'h44, 1'b0);
    send_request(OP_NONE, 8'd0, 1'b1, 4'd4, 48'd0, 8'd0, 5'd0, 5'd0);
    send_read(5'd0, 5'd0);
    send_request(OP_CLEAR, 8'd0, 1'b0, 4'd0, 48'd0, 8'd0, 5'd0, 5'd0);
    send_read(5'd0, 5'd0);

    // Fill beyond capacity with short frames so that the weakest entry gets replaced.
    for (int i = 0; i < 30; i++) begin
      frame_buf.delete();
      frame_buf.push_back(8'($urandom));
      send_frame(PROBE_REQ_SUBTYPE, 48'({$urandom, $urandom}), 8'($urandom), 1'b0);
    end
    drain();

    // Random part: well-formed probe requests mostly, some noise.
    for (int n = 0; n < 12; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        decl = $urandom_range(0, 9) == 0 ? $urandom_range(33, 255) : $urandom_range(0, 32);
        len = $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : decl > 32 ? 32 : decl;
        build_frame($urandom_range(0, 7) == 0 ? $urandom_range(1, 255) : 0, decl, len,
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : -1);
        sub = $urandom_range(0, 5) == 0 ? $urandom_range(0, 15) : PROBE_REQ_SUBTYPE;
        send_frame(4'(sub), $urandom_range(0, 4) == 0 ? 48'({$urandom, $urandom})
                   : mac_pool[$urandom_range(0, 7)], 8'($urandom), 1'b1);
      end else if (kind < 8) begin
        repeat ($urandom_range(1, 8)) begin
          send_read(5'($urandom_range(0, 31)), 5'($urandom));
          random_gap();
        end
      end else if (kind == 8) begin
        frame_buf.delete();
        repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom));
        send_frame(4'($urandom), mac_pool[$urandom_range(0, 7)], 8'($urandom), 1'b1);
      end else begin
        send_request($urandom_range(0, 1) ? OP_CLEAR : OP_NONE, 8'($urandom),
                     1'($urandom), 4'($urandom), 48'({$urandom, $urandom}),
                     8'($urandom), 5'($urandom), 5'($urandom));
      end
      if (n == 6) drain();
      random_gap();
    end
    for (int s = 0; s < TABLE_ENTRIES; s++) send_read(5'(s), 5'($urandom));

    drain();
    repeat (80) @(posedge clk);
    $display("Sent %0d frames; %0d frame reports (%0d taken) and %0d read replies checked.",
             frames_sent, report_count, taken_count, read_count);
    if (fail_count == 0 && pending_count == 0)
      $display("tb_probe_station_table_unit passed");
    else
      $display("tb_probe_station_table_unit failed");
    $finish;
  end
endmodule

/* filelist.f */
src/pst_pkg.sv
src/pst_cell.sv
src/probe_station_table_unit.sv
tb/pst_checker.sv
tb/tb_probe_station_table_unit.sv
